// File: design/nbfa_pkg.sv
package nbfa_pkg;

    // Field widths.
    localparam int POS_W   = 6;
    localparam int WAVE_W  = 8;
    localparam int VEL_W   = 32;
    localparam int CFG_W   = 32;
    localparam int TRIG_W  = 16;
    // Width of (2*pos+1)*wave before the modulo.
    localparam int PHASE_W = 15;

    // Polynomial for sin(pi/2 * t), t in Q0.30, coefficients in Q2.30.
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint C_A1    = 64'sd1686629713;
    localparam longint C_A3    = -64'sd693598668;
    localparam longint C_A5    = 64'sd85569306;
    localparam longint C_A7    = -64'sd5026994;
    localparam longint C_A9    = 64'sd172272;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_GAIN_X = 3'd0,
        CFG_GAIN_Y = 3'd1,
        CFG_GAIN_Z = 3'd2,
        CFG_WAVE_X = 3'd3,
        CFG_WAVE_Y = 3'd4,
        CFG_WAVE_Z = 3'd5
    } cfg_index_t;

    typedef logic signed [TRIG_W-1:0] trig_t;

    // Load enables for the four stages of one trig lane.
    typedef struct packed {
        logic mul;
        logic quo;
        logic rem;
        logic rd;
    } trig_en_t;

    // Shift right with rounding half away from zero (table build only).
    function automatic longint rnd_shift(input longint v, input int s);
        longint half;
        half = longint'(1) <<< (s - 1);
        if (v >= 0) begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

    // sin(pi/2 * t) for t in Q0.30, result in Q30 (table build only).
    function automatic longint quarter_sin(input longint t);
        longint t2;
        longint p;
        t2 = rnd_shift(t * t, 30);
        p  = C_A9;
        p  = C_A7 + rnd_shift(p * t2, 30);
        p  = C_A5 + rnd_shift(p * t2, 30);
        p  = C_A3 + rnd_shift(p * t2, 30);
        p  = C_A1 + rnd_shift(p * t2, 30);
        return rnd_shift(p * t, 30);
    endfunction

    // Q1.15 times Q1.15, rounded half away from zero back to Q1.15.
    // The callers never see a magnitude above 32767, so 16 bits hold it.
    function automatic trig_t round_q15(input logic signed [2*TRIG_W-1:0] p);
        logic signed [2*TRIG_W:0] w;
        w = $signed({p[2*TRIG_W-1], p}) + (2*TRIG_W+1)'(16384)
            - $signed({(2*TRIG_W)'(0), p[2*TRIG_W-1]});
        return trig_t'(w >>> 15);
    endfunction

    // Gain times Q1.15 factor, rounded half away from zero to Q16.16.
    function automatic logic signed [VEL_W:0] round_gain(
        input logic signed [VEL_W+TRIG_W-1:0] p
    );
        logic signed [VEL_W+TRIG_W:0] w;
        w = $signed({p[VEL_W+TRIG_W-1], p}) + (VEL_W+TRIG_W+1)'(16384)
            - $signed({(VEL_W+TRIG_W)'(0), p[VEL_W+TRIG_W-1]});
        return (VEL_W+1)'(w >>> 15);
    endfunction

endpackage

// File: design/nbfa_trig.sv
// One axis: phase index, then sine and cosine from a quarter-wave-exact table.
module nbfa_trig #(
    parameter int RES = 64
) (
    input  logic                             aclk,
    input  nbfa_pkg::trig_en_t               en,
    input  logic [nbfa_pkg::POS_W-1:0]       pos,
    input  logic [nbfa_pkg::WAVE_W-1:0]      wave,
    output nbfa_pkg::trig_t                  sin_val,
    output nbfa_pkg::trig_t                  cos_val
);

    localparam int PW    = nbfa_pkg::PHASE_W;
    localparam int STEPS = 4 * RES;
    localparam int NW    = $clog2(STEPS);
    // Reciprocal multiply: floor(v*RECIP >> SHIFT) is exact for v below 2^PW.
    localparam int SHIFT = PW + NW;
    localparam int RW    = PW + 2;
    localparam int MW    = PW + RW;
    localparam int RECIP = ((2 ** SHIFT) + STEPS - 1) / STEPS;

    typedef nbfa_pkg::trig_t rom_t [STEPS];

    // Sine of each phase step, Q1.15, built at elaboration.
    function automatic rom_t build_rom();
        rom_t   rom;
        longint p;
        longint t;
        longint q;
        longint s;
        for (int n = 0; n < STEPS; n++) begin
            p = (longint'(n) <<< 32) / STEPS;
            q = (p >>> 30) & 64'sd3;
            t = p & 64'sh3FFFFFFF;
            if ((q & 64'sd1) != 0) begin
                s = nbfa_pkg::quarter_sin(nbfa_pkg::Q30_ONE - t);
            end else begin
                s = nbfa_pkg::quarter_sin(t);
            end
            if ((q & 64'sd2) != 0) begin
                s = -s;
            end
            s = nbfa_pkg::rnd_shift(s, 15);
            if (s > 64'sd32767) begin
                s = 64'sd32767;
            end
            if (s < -64'sd32767) begin
                s = -64'sd32767;
            end
            rom[n] = nbfa_pkg::trig_t'(s);
        end
        return rom;
    endfunction

    localparam rom_t SIN_ROM = build_rom();

    logic [PW-1:0]    odd_next;
    logic [PW-1:0]    odd_reg;
    logic [MW-1:0]    recip_prod;
    logic [PW-1:0]    quo_next;
    logic [PW-1:0]    quo_reg;
    logic [PW-1:0]    odd2_reg;
    logic [PW-1:0]    rem_raw;
    logic [PW-1:0]    rem_fix;
    logic [NW-1:0]    phase_next;
    logic [NW-1:0]    phase_reg;
    logic [NW:0]      cos_sum;
    logic [NW-1:0]    cos_addr;
    nbfa_pkg::trig_t  sin_reg;
    nbfa_pkg::trig_t  cos_reg;

    // Stage one: (2*pos+1)*wave.
    assign odd_next = PW'({pos, 1'b1}) * PW'(wave);

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            odd_reg <= odd_next;
        end
    end

    // Stage two: quotient by the turn length through the reciprocal.
    assign recip_prod = MW'(odd_reg) * MW'(RECIP);
    assign quo_next   = PW'(recip_prod >> SHIFT);

    always_ff @(posedge aclk) begin
        if (en.quo) begin
            quo_reg  <= quo_next;
            odd2_reg <= odd_reg;
        end
    end

    // Stage three: remainder, with one correcting subtract.
    assign rem_raw    = odd2_reg - PW'(quo_reg * PW'(STEPS));
    assign rem_fix    = (rem_raw >= PW'(STEPS)) ? rem_raw - PW'(STEPS) : rem_raw;
    assign phase_next = NW'(rem_fix);

    always_ff @(posedge aclk) begin
        if (en.rem) begin
            phase_reg <= phase_next;
        end
    end

    // Stage four: cosine is the sine a quarter turn later.
    assign cos_sum  = (NW+1)'(phase_reg) + (NW+1)'(RES);
    assign cos_addr = (cos_sum >= (NW+1)'(STEPS)) ? NW'(cos_sum - (NW+1)'(STEPS))
                                                  : NW'(cos_sum);

    always_ff @(posedge aclk) begin
        if (en.rd) begin
            sin_reg <= SIN_ROM[phase_reg];
            cos_reg <= SIN_ROM[cos_addr];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// File: design/neumann_basis_field_accumulate.sv
// Pipeline of 9 register stages.
// Throughput: one cell per cycle while the output is taken; each stage holds one item and stalls only when full.
// Stages: phase product, reciprocal quotient, remainder, table read, two Q1.15 products,
// gain product, rounding, saturating add. Tables are constants built at elaboration.
// Reset (aresetn low, synchronous) clears all valid bits and the configuration registers.
module neumann_basis_field_accumulate #(
    parameter int X_RES = 64,
    parameter int Y_RES = 64,
    parameter int Z_RES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration writes.
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    // Cell stream in.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x[5:0], pos_y[11:6], pos_z[17:12], cur_x[49:18], cur_y[81:50],
    // cur_z[113:82], zero[119:114]
    input  logic [119:0] s_axis_tdata,
    // Updated cell stream out.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_x[31:0], new_y[63:32], new_z[95:64]
    output logic [95:0]  m_axis_tdata,
    // saturated[0]
    output logic [0:0]   m_axis_tuser
);

    localparam int NSTAGE = 9;
    localparam int VW     = nbfa_pkg::VEL_W;
    localparam int TW     = nbfa_pkg::TRIG_W;
    localparam int PW     = nbfa_pkg::POS_W;
    localparam int WW     = nbfa_pkg::WAVE_W;

    localparam logic signed [VW+1:0] VEL_MAX = (VW+2)'(2147483647);
    localparam logic signed [VW+1:0] VEL_MIN = -(VW+2)'(2147483647) - (VW+2)'(1);
    localparam logic signed [TW-1:0] TRIG_MIN = {1'b1, {(TW-1){1'b0}}};

    typedef struct packed {
        logic signed [VW-1:0] z;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] x;
    } vel_t;

    // Configuration registers.
    logic signed [VW-1:0] gain_x_reg, gain_y_reg, gain_z_reg;
    logic [WW-1:0]        wave_x_reg, wave_y_reg, wave_z_reg;

    // Handshake and stage control.
    logic [NSTAGE:1] valid_reg;
    logic [NSTAGE:1] valid_shift;
    logic [NSTAGE:1] stage_en;
    nbfa_pkg::trig_en_t trig_en;

    // Payload.
    vel_t            cur_in;
    vel_t            cur_reg [1:NSTAGE-1];
    nbfa_pkg::trig_t sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
    nbfa_pkg::trig_t m1_x_reg, m1_y_reg, m1_z_reg;
    nbfa_pkg::trig_t c3_x_reg, c3_y_reg, c3_z_reg;
    nbfa_pkg::trig_t m2_x_reg, m2_y_reg, m2_z_reg;
    logic signed [VW+TW-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [VW:0]      term_x_reg, term_y_reg, term_z_reg;
    logic signed [VW+1:0]    sum_x, sum_y, sum_z;
    logic                    hi_x, lo_x, hi_y, lo_y, hi_z, lo_z;
    logic signed [VW-1:0]    new_x_reg, new_y_reg, new_z_reg;
    logic                    sat_reg;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_x_reg <= '0;
            gain_y_reg <= '0;
            gain_z_reg <= '0;
            wave_x_reg <= '0;
            wave_y_reg <= '0;
            wave_z_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                nbfa_pkg::CFG_GAIN_X: gain_x_reg <= cfg_wdata;
                nbfa_pkg::CFG_GAIN_Y: gain_y_reg <= cfg_wdata;
                nbfa_pkg::CFG_GAIN_Z: gain_z_reg <= cfg_wdata;
                nbfa_pkg::CFG_WAVE_X: wave_x_reg <= cfg_wdata[WW-1:0];
                nbfa_pkg::CFG_WAVE_Y: wave_y_reg <= cfg_wdata[WW-1:0];
                nbfa_pkg::CFG_WAVE_Z: wave_z_reg <= cfg_wdata[WW-1:0];
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        stage_en[NSTAGE] = !valid_reg[NSTAGE] || m_axis_tready;
        for (int k = NSTAGE - 1; k >= 1; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_axis_tready = stage_en[1];
    assign valid_shift   = {valid_reg[NSTAGE-1:1], s_axis_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 1; k <= NSTAGE; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_shift[k];
                end
            end
        end
    end

    // Current velocity rides along until the final add.
    assign cur_in.x = s_axis_tdata[49:18];
    assign cur_in.y = s_axis_tdata[81:50];
    assign cur_in.z = s_axis_tdata[113:82];

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            cur_reg[1] <= cur_in;
        end
        for (int k = 2; k <= NSTAGE - 1; k++) begin
            if (stage_en[k]) begin
                cur_reg[k] <= cur_reg[k-1];
            end
        end
    end

    // Stages one to four: one trig lane per axis.
    assign trig_en.mul = stage_en[1];
    assign trig_en.quo = stage_en[2];
    assign trig_en.rem = stage_en[3];
    assign trig_en.rd  = stage_en[4];

    nbfa_trig #(.RES(X_RES)) u_trig_x (
        .aclk    (aclk),
        .en      (trig_en),
        .pos     (s_axis_tdata[PW-1:0]),
        .wave    (wave_x_reg),
        .sin_val (sin_x),
        .cos_val (cos_x)
    );

    nbfa_trig #(.RES(Y_RES)) u_trig_y (
        .aclk    (aclk),
        .en      (trig_en),
        .pos     (s_axis_tdata[2*PW-1:PW]),
        .wave    (wave_y_reg),
        .sin_val (sin_y),
        .cos_val (cos_y)
    );

    nbfa_trig #(.RES(Z_RES)) u_trig_z (
        .aclk    (aclk),
        .en      (trig_en),
        .pos     (s_axis_tdata[3*PW-1:2*PW]),
        .wave    (wave_z_reg),
        .sin_val (sin_z),
        .cos_val (cos_z)
    );

    // Stage five: first pair of factors.
    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            m1_x_reg <= nbfa_pkg::round_q15(cos_x * cos_y);
            m1_y_reg <= nbfa_pkg::round_q15(sin_x * sin_y);
            m1_z_reg <= nbfa_pkg::round_q15(sin_x * cos_y);
            c3_x_reg <= sin_z;
            c3_y_reg <= sin_z;
            c3_z_reg <= cos_z;
        end
    end

    // Stage six: third factor.
    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            m2_x_reg <= nbfa_pkg::round_q15(m1_x_reg * c3_x_reg);
            m2_y_reg <= nbfa_pkg::round_q15(m1_y_reg * c3_y_reg);
            m2_z_reg <= nbfa_pkg::round_q15(m1_z_reg * c3_z_reg);
        end
    end

    // Stage seven: gain product.
    always_ff @(posedge aclk) begin
        if (stage_en[7]) begin
            prod_x_reg <= (VW+TW)'(gain_x_reg) * (VW+TW)'(m2_x_reg);
            prod_y_reg <= (VW+TW)'(gain_y_reg) * (VW+TW)'(m2_y_reg);
            prod_z_reg <= (VW+TW)'(gain_z_reg) * (VW+TW)'(m2_z_reg);
        end
    end

    // Stage eight: round the product to Q16.16.
    always_ff @(posedge aclk) begin
        if (stage_en[8]) begin
            term_x_reg <= nbfa_pkg::round_gain(prod_x_reg);
            term_y_reg <= nbfa_pkg::round_gain(prod_y_reg);
            term_z_reg <= nbfa_pkg::round_gain(prod_z_reg);
        end
    end

    // Stage nine: saturating add into the output register.
    assign sum_x = (VW+2)'(cur_reg[NSTAGE-1].x) + (VW+2)'(term_x_reg);
    assign sum_y = (VW+2)'(cur_reg[NSTAGE-1].y) + (VW+2)'(term_y_reg);
    assign sum_z = (VW+2)'(cur_reg[NSTAGE-1].z) + (VW+2)'(term_z_reg);
    assign hi_x  = sum_x > VEL_MAX;
    assign lo_x  = sum_x < VEL_MIN;
    assign hi_y  = sum_y > VEL_MAX;
    assign lo_y  = sum_y < VEL_MIN;
    assign hi_z  = sum_z > VEL_MAX;
    assign lo_z  = sum_z < VEL_MIN;

    always_ff @(posedge aclk) begin
        if (stage_en[9]) begin
            new_x_reg <= hi_x ? VW'(VEL_MAX) : (lo_x ? VW'(VEL_MIN) : VW'(sum_x));
            new_y_reg <= hi_y ? VW'(VEL_MAX) : (lo_y ? VW'(VEL_MIN) : VW'(sum_y));
            new_z_reg <= hi_z ? VW'(VEL_MAX) : (lo_z ? VW'(VEL_MIN) : VW'(sum_z));
            sat_reg   <= hi_x | lo_x | hi_y | lo_y | hi_z | lo_z;
        end
    end

    assign m_axis_tvalid   = valid_reg[NSTAGE];
    assign m_axis_tdata    = {new_z_reg, new_y_reg, new_x_reg};
    assign m_axis_tuser[0] = sat_reg;

    // A flagged result has at least one component at a range limit.
    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (new_x_reg == VW'(VEL_MAX) || new_x_reg == VW'(VEL_MIN) ||
             new_y_reg == VW'(VEL_MAX) || new_y_reg == VW'(VEL_MIN) ||
             new_z_reg == VW'(VEL_MAX) || new_z_reg == VW'(VEL_MIN)))
        else $error("saturated flag without a clipped component");

    // Input is refused only when every stage holds an item.
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (&valid_reg))
        else $error("input stalled while the pipeline has a bubble");

    // Product of three clipped Q1.15 factors never reaches minus one.
    a_factor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[6] |->
            (m2_x_reg != TRIG_MIN && m2_y_reg != TRIG_MIN && m2_z_reg != TRIG_MIN))
        else $error("Q1.15 factor product out of range");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

// File: verif/neumann_basis_field_accumulate_tb.sv
`timescale 1ns / 1ps

module neumann_basis_field_accumulate_tb;

    localparam int X_RES           = 64;
    localparam int Y_RES           = 64;
    localparam int Z_RES           = 64;
    localparam int PIPE_LATENCY    = 9;
    localparam int GAP_MAX         = 12;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int HOLD_CYCLES     = 80;
    localparam int HOLD_ITEMS      = 40;

    // Indexes the block has no register for; writes to them must be ignored.
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    localparam logic signed [nbfa_pkg::VEL_W-1:0] VEL_MAX = 32'sh7fff_ffff;
    localparam logic signed [nbfa_pkg::VEL_W-1:0] VEL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [nbfa_pkg::POS_W-1:0]        pos_x;
        logic [nbfa_pkg::POS_W-1:0]        pos_y;
        logic [nbfa_pkg::POS_W-1:0]        pos_z;
        logic signed [nbfa_pkg::VEL_W-1:0] cur_x;
        logic signed [nbfa_pkg::VEL_W-1:0] cur_y;
        logic signed [nbfa_pkg::VEL_W-1:0] cur_z;
    } cell_t;

    typedef struct packed {
        logic signed [nbfa_pkg::VEL_W-1:0] new_x;
        logic signed [nbfa_pkg::VEL_W-1:0] new_y;
        logic signed [nbfa_pkg::VEL_W-1:0] new_z;
        logic                              sat;
    } velocity_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // pos_x[5:0], pos_y[11:6], pos_z[17:12], cur_x[49:18], cur_y[81:50],
    // cur_z[113:82], zero[119:114]
    logic [119:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // new_x[31:0], new_y[63:32], new_z[95:64]
    logic [95:0]  m_axis_tdata;
    // saturated[0]
    logic [0:0]   m_axis_tuser;

    // Copy of the register file as the block should hold it.
    logic signed [nbfa_pkg::VEL_W-1:0] gain_x_r, gain_y_r, gain_z_r;
    logic [nbfa_pkg::WAVE_W-1:0]       wave_x_r, wave_y_r, wave_z_r;

    velocity_t predicted_velocity_q[$];

    int tx_gap_max = GAP_MAX;
    int rx_gap_max = GAP_MAX;
    int rx_hold_cycles = 0;
    int cycles = 0;
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int sat_seen = 0;
    int settings_used = 0;

    neumann_basis_field_accumulate #(
        .X_RES(X_RES),
        .Y_RES(Y_RES),
        .Z_RES(Z_RES)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: a run that hangs ends here.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding.",
                 cycles, predicted_velocity_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Shift right by s, rounding half away from zero.
    function automatic longint shift_round(input longint v, input int s);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << (s - 1))) >> s;
        return (v < 0) ? -mag : mag;
    endfunction

    // sin(pi/2 * t) over one quadrant, t in Q0.30, result in Q30 (Horner form).
    function automatic longint quadrant_sine(input longint t);
        longint coef [5];
        longint t2;
        longint acc;
        coef = '{nbfa_pkg::C_A9, nbfa_pkg::C_A7, nbfa_pkg::C_A5,
                 nbfa_pkg::C_A3, nbfa_pkg::C_A1};
        t2   = shift_round(t * t, 30);
        acc  = coef[0];
        for (int i = 1; i < 5; i++) begin
            acc = coef[i] + shift_round(acc * t2, 30);
        end
        return shift_round(acc * t, 30);
    endfunction

    // Sine or cosine at phase n of a turn of 4*res steps, in Q1.15.
    function automatic longint phase_trig(input int unsigned n, input int unsigned res,
                                          input bit want_cos);
        logic [63:0] turn;
        logic [31:0] p;
        longint      t;
        longint      s;
        turn = (64'(n) << 32) / (64'(res) * 64'd4);
        p    = turn[31:0];
        if (want_cos) begin
            p = p + 32'h4000_0000;
        end
        t = longint'(p[29:0]);
        s = p[30] ? quadrant_sine(nbfa_pkg::Q30_ONE - t) : quadrant_sine(t);
        if (p[31]) begin
            s = -s;
        end
        s = shift_round(s, 15);
        if (s > 32767) begin
            s = 32767;
        end
        if (s < -32767) begin
            s = -32767;
        end
        return s;
    endfunction

    function automatic int unsigned phase_index(input logic [nbfa_pkg::POS_W-1:0] pos,
                                                input logic [nbfa_pkg::WAVE_W-1:0] wave,
                                                input int unsigned res);
        int unsigned odd;
        odd = 2 * int'(pos) + 1;
        return (odd * int'(wave)) % (4 * res);
    endfunction

    function automatic longint basis_term(input longint gain, input longint c1,
                                          input longint c2, input longint c3);
        longint m;
        m = shift_round(c1 * c2, 15);
        m = shift_round(m * c3, 15);
        return shift_round(gain * m, 15);
    endfunction

    // Updated velocity of one cell under the current register settings.
    function automatic velocity_t predict_update(input cell_t c);
        int unsigned nx, ny, nz;
        longint      sx, cx, sy, cy, sz, cz;
        longint      add [3];
        longint      sum [3];
        velocity_t   v;
        nx = phase_index(c.pos_x, wave_x_r, X_RES);
        ny = phase_index(c.pos_y, wave_y_r, Y_RES);
        nz = phase_index(c.pos_z, wave_z_r, Z_RES);
        sx = phase_trig(nx, X_RES, 1'b0);
        cx = phase_trig(nx, X_RES, 1'b1);
        sy = phase_trig(ny, Y_RES, 1'b0);
        cy = phase_trig(ny, Y_RES, 1'b1);
        sz = phase_trig(nz, Z_RES, 1'b0);
        cz = phase_trig(nz, Z_RES, 1'b1);
        add[0] = basis_term(longint'(gain_x_r), cx, cy, sz);
        add[1] = basis_term(longint'(gain_y_r), sx, sy, sz);
        add[2] = basis_term(longint'(gain_z_r), sx, cy, cz);
        sum[0] = longint'($signed(c.cur_x)) + add[0];
        sum[1] = longint'($signed(c.cur_y)) + add[1];
        sum[2] = longint'($signed(c.cur_z)) + add[2];
        v.sat = 1'b0;
        // Saturate each component to the signed 32-bit range.
        for (int i = 0; i < 3; i++) begin
            if (sum[i] > longint'(VEL_MAX)) begin
                sum[i] = longint'(VEL_MAX);
                v.sat  = 1'b1;
            end else if (sum[i] < longint'(VEL_MIN)) begin
                sum[i] = longint'(VEL_MIN);
                v.sat  = 1'b1;
            end
        end
        v.new_x = nbfa_pkg::VEL_W'(sum[0]);
        v.new_y = nbfa_pkg::VEL_W'(sum[1]);
        v.new_z = nbfa_pkg::VEL_W'(sum[2]);
        return v;
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return VEL_MAX;
            1: return VEL_MIN;
            2: return $urandom_range(0, 32'h0001_ffff);
            3: return -$urandom_range(0, 32'h0001_ffff);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_wave();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd255;
            2: return 32'd1;
            // Upper bits are junk the register must drop.
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [nbfa_pkg::VEL_W-1:0] pick_velocity();
        case ($urandom_range(0, 7))
            0: return VEL_MAX;
            1: return VEL_MIN;
            2: return VEL_MAX - $urandom_range(0, 32'h0010_0000);
            3: return VEL_MIN + $urandom_range(0, 32'h0010_0000);
            4: return $urandom_range(0, 32'h0003_ffff) - 32'sh0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        c.pos_x = nbfa_pkg::POS_W'($urandom);
        c.pos_y = nbfa_pkg::POS_W'($urandom);
        c.pos_z = nbfa_pkg::POS_W'($urandom);
        c.cur_x = pick_velocity();
        c.cur_y = pick_velocity();
        c.cur_z = pick_velocity();
        return c;
    endfunction

    function automatic cell_t make_cell(input int px, input int py, input int pz,
                                        input logic [31:0] vx, input logic [31:0] vy,
                                        input logic [31:0] vz);
        cell_t c;
        c.pos_x = nbfa_pkg::POS_W'(px);
        c.pos_y = nbfa_pkg::POS_W'(py);
        c.pos_z = nbfa_pkg::POS_W'(pz);
        c.cur_x = vx;
        c.cur_y = vy;
        c.cur_z = vz;
        return c;
    endfunction

    // Offer one cell after a random gap and hold it until the transfer.
    task automatic send_cell(input cell_t c);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, c.cur_z, c.cur_y, c.cur_x, c.pos_z, c.pos_y, c.pos_x};
        do @(posedge aclk); while (!s_axis_tready);
        predicted_velocity_q.push_back(predict_update(c));
        items_sent++;
    endtask

    // Stop offering cells and let the pipeline empty out.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (predicted_velocity_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            nbfa_pkg::CFG_GAIN_X: gain_x_r = data;
            nbfa_pkg::CFG_GAIN_Y: gain_y_r = data;
            nbfa_pkg::CFG_GAIN_Z: gain_z_r = data;
            nbfa_pkg::CFG_WAVE_X: wave_x_r = data[nbfa_pkg::WAVE_W-1:0];
            nbfa_pkg::CFG_WAVE_Y: wave_y_r = data[nbfa_pkg::WAVE_W-1:0];
            nbfa_pkg::CFG_WAVE_Z: wave_z_r = data[nbfa_pkg::WAVE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure_all(input logic [31:0] gx, input logic [31:0] gy,
                                 input logic [31:0] gz, input logic [31:0] wx,
                                 input logic [31:0] wy, input logic [31:0] wz);
        wait_idle();
        write_reg(nbfa_pkg::CFG_GAIN_X, gx);
        write_reg(nbfa_pkg::CFG_GAIN_Y, gy);
        write_reg(nbfa_pkg::CFG_GAIN_Z, gz);
        write_reg(nbfa_pkg::CFG_WAVE_X, wx);
        write_reg(nbfa_pkg::CFG_WAVE_Y, wy);
        write_reg(nbfa_pkg::CFG_WAVE_Z, wz);
        settings_used++;
    endtask

    // With every register at reset the velocity passes through unchanged.
    task automatic test_reset_state();
        send_cell(make_cell(0, 0, 0, VEL_MAX, VEL_MAX, VEL_MAX));
        send_cell(make_cell(63, 63, 63, VEL_MIN, VEL_MIN, VEL_MIN));
    endtask

    // A zero wave number gives a zero sine, so parts carrying it add nothing.
    task automatic test_zero_wave();
        configure_all(VEL_MAX, VEL_MAX, VEL_MAX, 0, 0, 0);
        send_cell(make_cell(17, 40, 5, 32'h0001_0000, 32'hffff_0000, 32'h0));
        send_cell(make_cell(63, 0, 63, VEL_MAX, VEL_MIN, 32'h1234_5678));
        configure_all(VEL_MAX, VEL_MAX, VEL_MAX, 0, 0, 5);
        send_cell(make_cell(9, 33, 3, 32'h0, 32'h0, 32'h0));
    endtask

    // Largest gains and wave numbers against the velocity limits.
    task automatic test_extremes();
        configure_all(VEL_MAX, VEL_MAX, VEL_MAX, 255, 255, 255);
        send_cell(make_cell(0, 0, 0, VEL_MAX, VEL_MAX, VEL_MAX));
        send_cell(make_cell(63, 63, 63, VEL_MIN, VEL_MIN, VEL_MIN));
        send_cell(make_cell(0, 63, 0, VEL_MIN, VEL_MAX, VEL_MIN));
        send_cell(make_cell(63, 0, 63, VEL_MAX, VEL_MIN, VEL_MAX));
        configure_all(VEL_MIN, VEL_MIN, VEL_MIN, 1, 1, 1);
        send_cell(make_cell(0, 0, 0, VEL_MIN, VEL_MIN, VEL_MIN));
        send_cell(make_cell(63, 63, 63, VEL_MAX, VEL_MAX, VEL_MAX));
        send_cell(make_cell(31, 32, 15, VEL_MIN, VEL_MAX, VEL_MIN));
        send_cell(make_cell(32, 31, 48, VEL_MAX, VEL_MIN, VEL_MAX));
    endtask

    // Writes to indexes beyond the register file change nothing.
    task automatic test_spare_index();
        wait_idle();
        write_reg(CFG_SPARE_A, 32'hffff_ffff);
        write_reg(CFG_SPARE_B, 32'h8000_0001);
        send_cell(make_cell(5, 21, 42, 32'h0000_8000, 32'hffff_8000, 32'h7000_0000));
        send_cell(make_cell(62, 1, 30, VEL_MIN, 32'h0, VEL_MAX));
    endtask

    // Wave registers keep only their low byte.
    task automatic test_wave_mask();
        wait_idle();
        write_reg(nbfa_pkg::CFG_WAVE_X, 32'hffff_ff03);
        write_reg(nbfa_pkg::CFG_WAVE_Y, 32'h1234_5680);
        write_reg(nbfa_pkg::CFG_WAVE_Z, 32'hdead_be7f);
        send_cell(make_cell(11, 22, 33, 32'h0, 32'h0, 32'h0));
        send_cell(make_cell(44, 55, 6, 32'h4000_0000, 32'hc000_0000, 32'h0));
    endtask

    // The receiver holds off while cells keep coming, so the pipeline fills.
    task automatic test_backpressure();
        configure_all(pick_gain(), pick_gain(), pick_gain(),
                      pick_wave(), pick_wave(), pick_wave());
        tx_gap_max     = 0;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (HOLD_ITEMS) send_cell(random_cell());
        tx_gap_max = GAP_MAX;
        wait_idle();
    endtask

    // Random cells over several random settings, some stretches without gaps.
    task automatic test_random_sweep();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            configure_all(pick_gain(), pick_gain(), pick_gain(),
                          pick_wave(), pick_wave(), pick_wave());
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            repeat (ITEMS_PER_PHASE) send_cell(random_cell());
        end
        tx_gap_max = GAP_MAX;
        rx_gap_max = GAP_MAX;
    endtask

    // Result side: random stalls, plus one long hold when asked for.
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, rx_gap_max);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    // Compare every result transfer against the oldest prediction.
    always @(posedge aclk) begin : result_check
        velocity_t want;
        velocity_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.new_x = m_axis_tdata[31:0];
            got.new_y = m_axis_tdata[63:32];
            got.new_z = m_axis_tdata[95:64];
            got.sat   = m_axis_tuser[0];
            if (predicted_velocity_q.size() == 0) begin
                $display("%0t: result transfer with none expected, actual %h %h %h %b",
                         $time, got.new_x, got.new_y, got.new_z, got.sat);
                errors++;
            end else begin
                want = predicted_velocity_q.pop_front();
                if (got.new_x !== want.new_x) begin
                    $display("%0t: new_x expected %h, actual %h", $time, want.new_x, got.new_x);
                    errors++;
                end
                if (got.new_y !== want.new_y) begin
                    $display("%0t: new_y expected %h, actual %h", $time, want.new_y, got.new_y);
                    errors++;
                end
                if (got.new_z !== want.new_z) begin
                    $display("%0t: new_z expected %h, actual %h", $time, want.new_z, got.new_z);
                    errors++;
                end
                if (got.sat !== want.sat) begin
                    $display("%0t: saturated expected %b, actual %b", $time, want.sat, got.sat);
                    errors++;
                end
                results_checked++;
                if (got.sat === 1'b1) begin
                    sat_seen++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= 3'd0;
        cfg_wdata     <= 32'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        gain_x_r = '0;
        gain_y_r = '0;
        gain_z_r = '0;
        wave_x_r = '0;
        wave_y_r = '0;
        wave_z_r = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_zero_wave();
        test_extremes();
        test_spare_index();
        test_wave_mask();
        test_backpressure();
        test_random_sweep();
        wait_idle();

        $display("Ran %0d cells over %0d register settings; %0d results checked, %0d saturated.",
                 items_sent, settings_used, results_checked, sat_seen);
        $display("Included a %0d-cycle receiver hold-off against a gapless sender.",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches found.", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
